// ===== src/imhd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imhd_pkg
// Shared constants and types of the indexed min-heap with decrease-key.
// ----------------------------------------------------------------------------
package imhd_pkg;

  // default sizes
  localparam int HEAP_DEPTH   = 1024;
  localparam int NODE_BITS    = 16;
  localparam int PRIO_BITS    = 32;
  localparam int PAYLOAD_BITS = 32;

  // port field widths
  localparam int REQ_W    = 2;
  localparam int NODE_W   = 16;
  localparam int PRIO_W   = 32;
  localparam int PAY_W    = 32;
  localparam int STATUS_W = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_VISIT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DECREASED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

  // result word from the core to the output register
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   node;
    logic [PRIO_W-1:0]   prio;
    logic [PAY_W-1:0]    pay;
    logic                now_empty;
  } res_t;

endpackage
`default_nettype wire

// ===== src/imhd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imhd_core
// Sequencer with heap memory and position map; read-modify-write sifting.
// ----------------------------------------------------------------------------
module imhd_core #(
  parameter int HEAP_DEPTH   = imhd_pkg::HEAP_DEPTH,
  parameter int NODE_BITS    = imhd_pkg::NODE_BITS,
  parameter int PRIO_BITS    = imhd_pkg::PRIO_BITS,
  parameter int PAYLOAD_BITS = imhd_pkg::PAYLOAD_BITS
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  [imhd_pkg::REQ_W-1:0]         in_req_i,
  input  wire  [NODE_BITS-1:0]               in_node_i,
  input  wire  [PRIO_BITS-1:0]               in_prio_i,
  input  wire  [PAYLOAD_BITS-1:0]            in_pay_i,
  output logic                               res_valid_o,
  input  wire                                res_ready_i,
  output imhd_pkg::res_t                     res_o
);

  localparam int IDX_BITS  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(HEAP_DEPTH + 1);
  localparam int MARK_BITS = $clog2(HEAP_DEPTH + 2);
  localparam int ENT_W     = NODE_BITS + PRIO_BITS + PAYLOAD_BITS;
  localparam int PRIO_LO   = PAYLOAD_BITS;
  localparam int NODE_LO   = PAYLOAD_BITS + PRIO_BITS;
  localparam int NODES     = 2 ** NODE_BITS;
  localparam int CW        = IDX_BITS + 2;

  localparam logic [MARK_BITS-1:0] MARK_UNSEEN = MARK_BITS'(0);
  localparam logic [MARK_BITS-1:0] MARK_DONE   = MARK_BITS'(1);
  localparam logic [MARK_BITS-1:0] MARK_SLOT0  = MARK_BITS'(2);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LOOK = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_UP   = 4'd4;
  localparam logic [3:0] S_UPC  = 4'd5;
  localparam logic [3:0] S_LAST = 4'd6;
  localparam logic [3:0] S_DN   = 4'd7;
  localparam logic [3:0] S_DNL  = 4'd8;
  localparam logic [3:0] S_DNR  = 4'd9;
  localparam logic [3:0] S_DNC  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  // memories
  logic [ENT_W-1:0]     heap_mem [HEAP_DEPTH];
  logic [MARK_BITS-1:0] pmap_mem [NODES];

  logic                 hm_we;
  logic [IDX_BITS-1:0]  hm_waddr, hm_raddr;
  logic [ENT_W-1:0]     hm_wdata, hm_rdata_q;
  logic                 pm_we;
  logic [NODE_BITS-1:0] pm_waddr, pm_raddr;
  logic [MARK_BITS-1:0] pm_wdata, pm_rdata_q;

  always_ff @(posedge clk_i) begin
    if (hm_we) heap_mem[hm_waddr] <= hm_wdata;
    hm_rdata_q <= heap_mem[hm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) pmap_mem[pm_waddr] <= pm_wdata;
    pm_rdata_q <= pmap_mem[pm_raddr];
  end

  // registers
  logic [3:0]                    state_q, state_d;
  logic [NODE_BITS-1:0]          clr_q, clr_d;
  logic [imhd_pkg::REQ_W-1:0]    req_q, req_d;
  logic [ENT_W-1:0]              mov_q, mov_d, lch_q, lch_d, best_q, best_d;
  logic [IDX_BITS-1:0]           idx_q, idx_d, bidx_q, bidx_d;
  logic [CNT_BITS-1:0]           cnt_q, cnt_d;
  logic [imhd_pkg::STATUS_W-1:0] status_q, status_d;
  logic [ENT_W-1:0]              out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    mov_q    <= mov_d;
    lch_q    <= lch_d;
    best_q   <= best_d;
    idx_q    <= idx_d;
    bidx_q   <= bidx_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  // field views
  logic [PRIO_BITS-1:0] mov_prio, rd_prio, lch_prio, best_prio;
  logic [NODE_BITS-1:0] mov_node, rd_node, best_node;
  logic [MARK_BITS-1:0] slot_mark, idx_mark;
  logic [IDX_BITS-1:0]  parent_idx;
  logic [CW-1:0]        c_w, c1_w, cnt_w;

  assign mov_prio   = mov_q[PRIO_LO +: PRIO_BITS];
  assign mov_node   = mov_q[NODE_LO +: NODE_BITS];
  assign rd_prio    = hm_rdata_q[PRIO_LO +: PRIO_BITS];
  assign rd_node    = hm_rdata_q[NODE_LO +: NODE_BITS];
  assign lch_prio   = lch_q[PRIO_LO +: PRIO_BITS];
  assign best_prio  = best_q[PRIO_LO +: PRIO_BITS];
  assign best_node  = best_q[NODE_LO +: NODE_BITS];
  assign slot_mark  = pm_rdata_q - MARK_SLOT0;
  assign idx_mark   = MARK_BITS'(idx_q) + MARK_SLOT0;
  assign parent_idx = (idx_q - IDX_BITS'(1)) >> 1;
  assign c_w        = CW'({idx_q, 1'b1});
  assign c1_w       = c_w + CW'(1);
  assign cnt_w      = CW'(cnt_q);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    req_d    = req_q;
    mov_d    = mov_q;
    lch_d    = lch_q;
    best_d   = best_q;
    idx_d    = idx_q;
    bidx_d   = bidx_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    out_d    = out_q;
    hm_we    = 1'b0;
    hm_waddr = idx_q;
    hm_wdata = mov_q;
    hm_raddr = '0;
    pm_we    = 1'b0;
    pm_waddr = mov_node;
    pm_wdata = idx_mark;
    pm_raddr = in_node_i;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_CLR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_q;
        pm_wdata = MARK_UNSEEN;
        clr_d    = clr_q + NODE_BITS'(1);
        if (clr_q == {NODE_BITS{1'b1}}) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d    = in_req_i;
          mov_d    = {in_node_i, in_prio_i, in_pay_i};
          status_d = imhd_pkg::ST_IGNORED;
          out_d    = '0;
          state_d  = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_DONE;
        case (req_q)
          imhd_pkg::REQ_INSERT: begin
            if (pm_rdata_q == MARK_UNSEEN) begin
              if (cnt_q == CNT_BITS'(HEAP_DEPTH)) begin
                status_d = imhd_pkg::ST_FULL;
              end else begin
                idx_d    = cnt_q[IDX_BITS-1:0];
                cnt_d    = cnt_q + CNT_BITS'(1);
                status_d = imhd_pkg::ST_INSERTED;
                state_d  = S_UP;
              end
            end else if (pm_rdata_q >= MARK_SLOT0) begin
              hm_raddr = slot_mark[IDX_BITS-1:0];
              idx_d    = slot_mark[IDX_BITS-1:0];
              state_d  = S_DEC;
            end
          end
          imhd_pkg::REQ_VISIT: begin
            if (pm_rdata_q == MARK_UNSEEN) begin
              pm_we    = 1'b1;
              pm_wdata = MARK_DONE;
              status_d = imhd_pkg::ST_INSERTED;
            end
          end
          imhd_pkg::REQ_POP: begin
            if (cnt_q == '0) begin
              status_d = imhd_pkg::ST_EMPTY;
            end else begin
              out_d    = hm_rdata_q;
              pm_we    = 1'b1;
              pm_waddr = rd_node;
              pm_wdata = MARK_DONE;
              cnt_d    = cnt_q - CNT_BITS'(1);
              status_d = imhd_pkg::ST_POPPED;
              if (cnt_q != CNT_BITS'(1)) begin
                hm_raddr = IDX_BITS'(cnt_q - CNT_BITS'(1));
                state_d  = S_LAST;
              end
            end
          end
          default: ;
        endcase
      end
      S_DEC: begin
        if (mov_prio < rd_prio) begin
          status_d = imhd_pkg::ST_DECREASED;
          state_d  = S_UP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_UP: begin
        if (idx_q == '0) begin
          hm_we   = 1'b1;
          pm_we   = 1'b1;
          state_d = S_DONE;
        end else begin
          hm_raddr = parent_idx;
          state_d  = S_UPC;
        end
      end
      S_UPC: begin
        hm_we = 1'b1;
        pm_we = 1'b1;
        if (rd_prio <= mov_prio) begin
          state_d = S_DONE;
        end else begin
          // parent moves down into this slot
          hm_wdata = hm_rdata_q;
          pm_waddr = rd_node;
          idx_d    = parent_idx;
          state_d  = S_UP;
        end
      end
      S_LAST: begin
        mov_d   = hm_rdata_q;
        idx_d   = '0;
        state_d = S_DN;
      end
      S_DN: begin
        if (c_w >= cnt_w) begin
          hm_we   = 1'b1;
          pm_we   = 1'b1;
          state_d = S_DONE;
        end else begin
          hm_raddr = c_w[IDX_BITS-1:0];
          state_d  = S_DNL;
        end
      end
      S_DNL: begin
        lch_d  = hm_rdata_q;
        best_d = hm_rdata_q;
        bidx_d = c_w[IDX_BITS-1:0];
        if (c1_w < cnt_w) begin
          hm_raddr = c1_w[IDX_BITS-1:0];
          state_d  = S_DNR;
        end else begin
          state_d = S_DNC;
        end
      end
      S_DNR: begin
        // right child wins only when strictly smaller
        if (rd_prio < lch_prio) begin
          best_d = hm_rdata_q;
          bidx_d = c1_w[IDX_BITS-1:0];
        end
        state_d = S_DNC;
      end
      S_DNC: begin
        hm_we = 1'b1;
        pm_we = 1'b1;
        if (best_prio >= mov_prio) begin
          state_d = S_DONE;
        end else begin
          hm_wdata = best_q;
          pm_waddr = best_node;
          idx_d    = bidx_q;
          state_d  = S_DN;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_o.status    = status_q;
    res_o.node      = imhd_pkg::NODE_W'(out_q[NODE_LO +: NODE_BITS]);
    res_o.prio      = imhd_pkg::PRIO_W'(out_q[PRIO_LO +: PRIO_BITS]);
    res_o.pay       = imhd_pkg::PAY_W'(out_q[PAYLOAD_BITS-1:0]);
    res_o.now_empty = (cnt_q == '0);
  end

endmodule
`default_nettype wire

// ===== src/indexed_min_heap_decrease_key_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_top
// Indexed binary min-heap with decrease-key, stream ports, registered output.
// ----------------------------------------------------------------------------
// After reset the position map is swept to "unseen", one node per cycle, and
// the block takes no word until every node of the map has been swept. Each
// request then runs its lookup and its sift: insert or decrease reads and
// compares the parent for each level climbed, delete-min reads the left and
// then the right child and compares for each level sunk, since the single
// heap memory read port fetches parent or each child in turn and its read
// data is registered. A finished result sits in the output register while
// the next word is accepted.
module indexed_min_heap_decrease_key_top #(
  parameter int HEAP_DEPTH   = imhd_pkg::HEAP_DEPTH,
  parameter int NODE_BITS    = imhd_pkg::NODE_BITS,
  parameter int PRIO_BITS    = imhd_pkg::PRIO_BITS,
  parameter int PAYLOAD_BITS = imhd_pkg::PAYLOAD_BITS
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [79:0] s_axis_tdata,  // node_id[15:0], priority_req[47:16], payload[79:48]
  input  wire  [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [87:0] m_axis_tdata,  // out_node_id[15:0], out_priority[47:16],
                                     // out_payload[79:48], now_empty[80], zero[87:81]
  output logic [2:0]  m_axis_tuser   // status[2:0]
);

  logic           res_valid, res_ready;
  imhd_pkg::res_t res;
  imhd_pkg::res_t out_q;
  logic           out_valid_q;

  imhd_core #(
    .HEAP_DEPTH  (HEAP_DEPTH),
    .NODE_BITS   (NODE_BITS),
    .PRIO_BITS   (PRIO_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (s_axis_tuser),
    .in_node_i  (NODE_BITS'(s_axis_tdata[15:0])),
    .in_prio_i  (PRIO_BITS'(s_axis_tdata[47:16])),
    .in_pay_i   (PAYLOAD_BITS'(s_axis_tdata[79:48])),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {7'd0, out_q.now_empty, out_q.pay, out_q.prio, out_q.node};

`ifndef NO_ASSERTIONS
  // ready drops right after an accept, while the sequencer is busy with the request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");

  // an empty report leaves the heap empty
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == imhd_pkg::ST_EMPTY |-> m_axis_tdata[80])
    else $error("empty status without now_empty");

  // only a pop carries entry fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != imhd_pkg::ST_POPPED |-> m_axis_tdata[79:0] == '0)
    else $error("entry fields set on non-pop result");
`endif

endmodule
`default_nettype wire
